[hw/rtl/sai_pkg.sv]
`default_nettype none

package sai_pkg;

	localparam int CAPACITY_DEF = 128;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int POS_W  = 7;
	localparam int CNT_W  = 8;
	localparam int CFG_W  = 8;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FILL   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NOP    = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/sorted_array_insert_delete.sv]
`default_nettype none

// Sorted array keeper: an ascending array of signed 32-bit entries in one
// single-port-write, registered-read memory, plus a live count. A command is
// taken when start is high and busy is low; its one result is shown on
// status/position/count for exactly one cycle with done high, and it cannot
// be held off. busy drops in that same cycle, so the next command may start
// there. The time from accept to done is set by the memory sweep (one entry
// per cycle, the read registered ahead of the write-back):
//   insert: walks down from the top to the insertion point, then places the
//           value; goes straight to placement into an empty array, no sweep if full;
//   delete: walks up the whole array, no sweep if count is 0;
//   fill:   writes n entries with n = min(fill_count, CAPACITY), none if n is 0;
//   no-op:  no sweep.
// fill_count is written through cfg_valid/cfg_ready while busy is low.
module sorted_array_insert_delete #(
	parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [sai_pkg::FUNC_W-1:0]  func,
	input  wire logic [sai_pkg::DATA_W-1:0]  value,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sai_pkg::CFG_W-1:0]   cfg_data,
	output logic                             done,
	output logic [sai_pkg::STAT_W-1:0]       status,
	output logic [sai_pkg::POS_W-1:0]        position,
	output logic [sai_pkg::CNT_W-1:0]        count
);
	import sai_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {S_IDLE, S_FILL, S_INS, S_DEL, S_PUT} state_t;

	function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] a);
		logic [31:0] w;
		w = 32'(a);
		return w[POS_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[CNT_W-1:0];
	endfunction

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CFG_W-1:0]        fill_q;
	logic [DATA_W-1:0]       val_q;
	logic [AW-1:0]           ra_q;
	logic                    issue_q;
	logic                    found_q;
	logic [AW-1:0]           wpos_q;
	logic [AW-1:0]           fa_q;
	logic [CW-1:0]           n_q;
	logic                    rv_s1;
	logic [AW-1:0]           radr_s1;
	logic [DATA_W-1:0]       rdata_s1;
	logic                    done_q;
	logic [STAT_W-1:0]       status_q;
	logic [POS_W-1:0]        pos_q;
	logic [CNT_W-1:0]        res_cnt_q;

	logic [DATA_W-1:0]       mem [CAPACITY];

	logic                    rd_en;
	logic                    we;
	logic [AW-1:0]           wa;
	logic [DATA_W-1:0]       wd;
	logic                    gt;
	logic                    eq;
	logic [CW-1:0]           fill_n;
	logic                    del_last;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign status    = status_q;
	assign position  = pos_q;
	assign count     = res_cnt_q;

	assign rd_en    = issue_q && (state_q == S_INS || state_q == S_DEL);
	assign gt       = $signed(rdata_s1) > $signed(val_q);
	assign eq       = (rdata_s1 == val_q);
	assign del_last = (CW'(radr_s1) + CW'(1)) == cnt_q;

	always_comb begin
		if (32'(fill_q) > 32'(CAPACITY)) begin
			fill_n = CW'(CAPACITY);
		end else begin
			fill_n = CW'(fill_q);
		end
	end

	// single write port: fill sweep, shift moves and final placement
	always_comb begin
		we = 1'b0;
		wa = fa_q;
		wd = 32'(fa_q) + 32'd1;
		case (state_q)
			S_FILL: begin
				we = 1'b1;
			end
			S_INS: begin
				we = rv_s1 && gt;
				wa = radr_s1 + AW'(1);
				wd = rdata_s1;
			end
			S_DEL: begin
				we = rv_s1 && found_q;
				wa = radr_s1 - AW'(1);
				wd = rdata_s1;
			end
			S_PUT: begin
				we = 1'b1;
				wa = wpos_q;
				wd = val_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_s1 <= mem[ra_q];
		end
		radr_s1 <= ra_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			fill_q    <= '0;
			ra_q      <= '0;
			issue_q   <= 1'b0;
			found_q   <= 1'b0;
			wpos_q    <= '0;
			fa_q      <= '0;
			n_q       <= '0;
			rv_s1     <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
			pos_q     <= '0;
			res_cnt_q <= '0;
			val_q     <= '0;
		end else begin
			done_q <= 1'b0;
			rv_s1  <= rd_en;
			if (cfg_valid && cfg_ready) begin
				fill_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q <= value;
						case (func)
							FN_FILL: begin
								if (fill_n == '0) begin
									cnt_q     <= '0;
									done_q    <= 1'b1;
									status_q  <= ST_DONE;
									pos_q     <= '0;
									res_cnt_q <= '0;
								end else begin
									n_q     <= fill_n;
									fa_q    <= '0;
									state_q <= S_FILL;
								end
							end
							FN_INSERT: begin
								if (cnt_q == CW'(CAPACITY)) begin
									done_q    <= 1'b1;
									status_q  <= ST_FULL;
									pos_q     <= '0;
									res_cnt_q <= to_cnt(cnt_q);
								end else if (cnt_q == '0) begin
									wpos_q  <= '0;
									state_q <= S_PUT;
								end else begin
									ra_q    <= AW'(cnt_q - CW'(1));
									issue_q <= 1'b1;
									state_q <= S_INS;
								end
							end
							FN_DELETE: begin
								if (cnt_q == '0) begin
									done_q    <= 1'b1;
									status_q  <= ST_NOT_FOUND;
									pos_q     <= '0;
									res_cnt_q <= '0;
								end else begin
									ra_q    <= '0;
									issue_q <= 1'b1;
									found_q <= 1'b0;
									state_q <= S_DEL;
								end
							end
							default: begin
								done_q    <= 1'b1;
								status_q  <= ST_DONE;
								pos_q     <= '0;
								res_cnt_q <= to_cnt(cnt_q);
							end
						endcase
					end
				end
				S_FILL: begin
					if ((CW'(fa_q) + CW'(1)) == n_q) begin
						cnt_q     <= n_q;
						done_q    <= 1'b1;
						status_q  <= ST_DONE;
						pos_q     <= '0;
						res_cnt_q <= to_cnt(n_q);
						state_q   <= S_IDLE;
					end else begin
						fa_q <= fa_q + AW'(1);
					end
				end
				S_INS: begin
					// walk down from the top; larger entries move up one slot
					if (rd_en) begin
						ra_q    <= ra_q - AW'(1);
						issue_q <= (ra_q != '0);
					end
					if (rv_s1) begin
						if (gt) begin
							if (radr_s1 == '0) begin
								wpos_q  <= '0;
								issue_q <= 1'b0;
								state_q <= S_PUT;
							end
						end else begin
							wpos_q  <= radr_s1 + AW'(1);
							issue_q <= 1'b0;
							state_q <= S_PUT;
						end
					end
				end
				S_PUT: begin
					cnt_q     <= cnt_q + CW'(1);
					done_q    <= 1'b1;
					status_q  <= ST_DONE;
					pos_q     <= to_pos(wpos_q);
					res_cnt_q <= to_cnt(cnt_q + CW'(1));
					state_q   <= S_IDLE;
				end
				S_DEL: begin
					// walk up; after the match each entry moves down one slot
					if (rd_en) begin
						ra_q    <= ra_q + AW'(1);
						issue_q <= (CW'(ra_q) + CW'(1)) != cnt_q;
					end
					if (rv_s1) begin
						if (!found_q && eq) begin
							found_q <= 1'b1;
							wpos_q  <= radr_s1;
						end
						if (del_last) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							if (found_q || eq) begin
								cnt_q     <= cnt_q - CW'(1);
								status_q  <= ST_DONE;
								pos_q     <= found_q ? to_pos(wpos_q) : to_pos(radr_s1);
								res_cnt_q <= to_cnt(cnt_q - CW'(1));
							end else begin
								status_q  <= ST_NOT_FOUND;
								pos_q     <= '0;
								res_cnt_q <= to_cnt(cnt_q);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/tb_sorted_array_insert_delete.sv]
`timescale 1ns / 1ps

module tb_sorted_array_insert_delete;
	import sai_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	// room for the longest sweep, which grows with count; a little slack on top
	localparam int DRAIN_CYCLES = CAP + 16;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
	} outcome_t;

	typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CFG_W-1:0]  cfg;
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		bit                typed;
		outcome_t          res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [FUNC_W-1:0] func;
	logic [DATA_W-1:0] value;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  position;
	logic [CNT_W-1:0]  count;

	// shadow copy of the array, its count and the fill register
	logic [DATA_W-1:0] shadow_entries [CAP];
	int                shadow_count;
	logic [CFG_W-1:0]  shadow_fill;

	outcome_t          pending_outcomes [$];
	stim_row_t         directed_rows [$];
	int                errors;
	int                sender_idle_pct;

	sorted_array_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.status    (status),
		.position  (position),
		.count     (count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#10_000_000;
		$display("tb_sorted_array_insert_delete failed");
		$finish;
	end

	function automatic outcome_t apply_command(input logic [FUNC_W-1:0] f,
			input logic [DATA_W-1:0] v);
		outcome_t r;
		int p;
		int n;
		r = '0;
		r.st = ST_DONE;
		case (f)
		FN_FILL: begin
			n = (shadow_fill > CAP) ? CAP : shadow_fill;
			for (int i = 0; i < n; i++)
				shadow_entries[i] = i + 1;
			shadow_count = n;
		end
		FN_INSERT: begin
			if (shadow_count >= CAP) begin
				r.st = ST_FULL;
			end else begin
				// equal entries stay ahead of the new one
				p = 0;
				while (p < shadow_count && !($signed(shadow_entries[p]) > $signed(v)))
					p++;
				for (int i = shadow_count; i > p; i--)
					shadow_entries[i] = shadow_entries[i-1];
				shadow_entries[p] = v;
				shadow_count++;
				r.pos = p[POS_W-1:0];
			end
		end
		FN_DELETE: begin
			p = 0;
			while (p < shadow_count && shadow_entries[p] != v)
				p++;
			if (p >= shadow_count) begin
				r.st = ST_NOT_FOUND;
			end else begin
				for (int i = p; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i+1];
				shadow_count--;
				r.pos = p[POS_W-1:0];
			end
		end
		default: ;
		endcase
		r.cnt = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected result: got status %0d position %0d %s %0d",
						$time, status, position, "count", count);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.st || position !== want.pos || count !== want.cnt) begin
					if (errors < MAX_REPORTS)
						$display({"%0t: mismatch: expected status %0d position %0d count %0d,",
							" got status %0d position %0d count %0d"},
							$time, want.st, want.pos, want.cnt, status, position, count);
					errors++;
				end
			end
		end
	end

	// present one command until it is taken; start drops at random while waiting
	task automatic present(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
		bit on;
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			on = ($urandom_range(99) >= sender_idle_pct);
			start <= on;
			if (on) begin
				func <= f;
				value <= v;
			end else begin
				func <= FUNC_W'($urandom);
				value <= $urandom;
			end
			@(posedge clk);
			taken = on && !busy;
		end
	endtask

	task automatic write_fill(input logic [CFG_W-1:0] c);
		start <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0 || busy);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= CFG_W'($urandom);
		shadow_fill = c;
	endtask

	task automatic add_row(input row_kind_t k, input logic [CFG_W-1:0] c,
			input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v, input bit typed,
			input logic [STAT_W-1:0] st, input int pos, input int cnt);
		stim_row_t row;
		row.kind = k;
		row.cfg = c;
		row.f = f;
		row.v = v;
		row.typed = typed;
		row.res.st = st;
		row.res.pos = pos[POS_W-1:0];
		row.res.cnt = cnt[CNT_W-1:0];
		directed_rows.push_back(row);
	endtask

	task automatic run_phase(input int idle_pct, input int n_items);
		int insert_pct;
		int r;
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		outcome_t pred;
		sender_idle_pct = idle_pct;
		insert_pct = 50;
		for (int k = 0; k < n_items; k++) begin
			// every 50 commands: new insert/delete balance, maybe a new fill size
			if (k % 50 == 0) begin
				case ($urandom_range(2))
				0: insert_pct = 80;
				1: insert_pct = 50;
				default: insert_pct = 20;
				endcase
				if ($urandom_range(1)) begin
					case ($urandom_range(7))
					0: write_fill(8'd0);
					1: write_fill(8'd1);
					2: write_fill(8'd127);
					3: write_fill(8'd128);
					4: write_fill(8'd129);
					5: write_fill(8'd255);
					default: write_fill(CFG_W'($urandom_range(255)));
					endcase
				end
			end
			r = $urandom_range(99);
			if (r < 3)
				f = FN_NOP;
			else if (r < 7)
				f = FN_FILL;
			else if (r < 7 + insert_pct * 93 / 100)
				f = FN_INSERT;
			else
				f = FN_DELETE;
			r = $urandom_range(9);
			if (f == FN_DELETE) begin
				if (r < 7 && shadow_count > 0)
					v = shadow_entries[$urandom_range(shadow_count - 1)];
				else if (r < 9)
					v = $urandom_range(16) - 8;
				else
					v = $urandom;
			end else begin
				if (r < 4)
					v = $urandom;
				else if (r < 7)
					v = $urandom_range(16) - 8;
				else if (r < 9 && shadow_count > 0)
					v = shadow_entries[$urandom_range(shadow_count - 1)];
				else
					v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			present(f, v);
			pred = apply_command(f, v);
			pending_outcomes.push_back(pred);
		end
	endtask

	initial begin : stimulus
		outcome_t pred;
		int wait_cycles;
		start <= 1'b0;
		func <= '0;
		value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		errors = 0;
		shadow_count = 0;
		shadow_fill = '0;
		sender_idle_pct = 22;

		add_row(ROW_CMD, 0, FN_DELETE, 32'd0,         1, ST_NOT_FOUND, 0, 0);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd0,         1, ST_DONE, 0, 1);
		add_row(ROW_CMD, 0, FN_NOP,    32'hFFFF_FFFF, 1, ST_DONE, 0, 1);
		add_row(ROW_CMD, 0, FN_INSERT, 32'h7FFF_FFFF, 1, ST_DONE, 1, 2);
		add_row(ROW_CMD, 0, FN_INSERT, 32'h8000_0000, 1, ST_DONE, 0, 3);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd0,         1, ST_DONE, 2, 4);
		add_row(ROW_CMD, 0, FN_INSERT, 32'hFFFF_FFFF, 1, ST_DONE, 1, 5);
		add_row(ROW_CMD, 0, FN_DELETE, 32'd0,         1, ST_DONE, 2, 4);
		add_row(ROW_CMD, 0, FN_DELETE, 32'h8000_0000, 1, ST_DONE, 0, 3);
		add_row(ROW_CMD, 0, FN_DELETE, 32'd5,         1, ST_NOT_FOUND, 0, 3);
		add_row(ROW_CFG, 8'd0,   FN_NOP, 0, 0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_FILL,   32'h5A5A_A5A5, 1, ST_DONE, 0, 0);
		add_row(ROW_CFG, 8'd255, FN_NOP, 0, 0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_FILL,   32'hA5A5_5A5A, 1, ST_DONE, 0, 128);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd5,         1, ST_FULL, 0, 128);
		add_row(ROW_CMD, 0, FN_DELETE, 32'd128,       1, ST_DONE, 127, 127);
		add_row(ROW_CMD, 0, FN_DELETE, 32'd1,         1, ST_DONE, 0, 126);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd64,        0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd200,       0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_INSERT, 32'hFFFF_FFFB, 1, ST_FULL, 0, 128);
		add_row(ROW_CFG, 8'd128, FN_NOP, 0, 0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_FILL,   32'd0,         1, ST_DONE, 0, 128);
		add_row(ROW_CFG, 8'd129, FN_NOP, 0, 0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_FILL,   32'd0,         1, ST_DONE, 0, 128);
		add_row(ROW_CFG, 8'd1,   FN_NOP, 0, 0, ST_DONE, 0, 0);
		add_row(ROW_CMD, 0, FN_FILL,   32'd0,         1, ST_DONE, 0, 1);
		add_row(ROW_CMD, 0, FN_INSERT, 32'd1,         1, ST_DONE, 1, 2);
		add_row(ROW_CMD, 0, FN_DELETE, 32'd1,         1, ST_DONE, 0, 1);
		add_row(ROW_CMD, 0, FN_NOP,    32'd0,         1, ST_DONE, 0, 1);
		add_row(ROW_CMD, 0, FN_DELETE, 32'h7FFF_FFFF, 1, ST_NOT_FOUND, 0, 1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_fill(directed_rows[i].cfg);
			end else begin
				present(directed_rows[i].f, directed_rows[i].v);
				pred = apply_command(directed_rows[i].f, directed_rows[i].v);
				pending_outcomes.push_back(directed_rows[i].typed ? directed_rows[i].res : pred);
			end
		end

		run_phase(22, 575);
		run_phase(50, 575);
		run_phase(0, 575);

		start <= 1'b0;
		wait_cycles = 0;
		while (pending_outcomes.size() != 0 && wait_cycles < 4 * DRAIN_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_outcomes.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_sorted_array_insert_delete passed");
		else
			$display("tb_sorted_array_insert_delete failed");
		$finish;
	end

endmodule
